// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/pwft_pkg.sv =====
package pwft_pkg;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SCALAR  = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_WIRE_TYPE = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_err;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Varints hold at most ten bytes, so the byte index stops at nine.
    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [3:0] FIXED64_BYTES   = 4'd8;
    localparam logic [3:0] FIXED32_BYTES   = 4'd4;
    localparam logic [5:0] VARINT_DIGIT    = 6'd7;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_message;
    } t_beat;

    typedef struct packed {
        t_kind       kind;
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        payload_last;
        t_err        error_code;
        logic        message_done;
    } t_token;

endpackage

// ===== hw/rtl/pwft_byte_if.sv =====
interface pwft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_message;

    modport source (output valid, output byte_value, output end_of_message, input ready);
    modport sink (input valid, input byte_value, input end_of_message, output ready);
endinterface

// ===== hw/rtl/pwft_tok_if.sv =====
interface pwft_tok_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [28:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  error_code;
    logic        message_done;

    modport source (
        output valid, output kind, output field_number, output wire_type, output value,
        output payload_byte, output payload_last, output error_code, output message_done,
        input ready
    );
    modport sink (
        input valid, input kind, input field_number, input wire_type, input value,
        input payload_byte, input payload_last, input error_code, input message_done,
        output ready
    );
endinterface

// ===== hw/rtl/protobuf_wire_field_tokenizer.sv =====
// Channel  Port   Dir  Beat contents
// -------  -----  ---  ------------------------------------------------------------
// bytes    i_in   in   byte_value, end_of_message
// tokens   o_out  out  kind, field_number, wire_type, value, payload_byte,
//                      payload_last, error_code, message_done
//
// One byte is taken per cycle unless the token register stalls; the byte is held in the
// input register and any token it yields in the token register. The rate is set by the
// byte decoder, which updates its field state once per byte between the two registers.
// Reset (synchronous, active low) empties both registers and restarts at a tag.
// A stalled token holds in the token register while the input register still fills.
module protobuf_wire_field_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pwft_byte_if.sink  i_in,
    pwft_tok_if.source o_out
);
    import pwft_pkg::*;

    logic   r_in_valid;
    t_beat  r_in;
    logic   r_out_valid;
    t_token r_tok;
    logic   advance;
    logic   emit;
    t_token tok;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    pwft_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_beat  (r_in),
        .o_emit  (emit),
        .o_token (tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.byte_value     <= i_in.byte_value;
            r_in.end_of_message <= i_in.end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_tok <= tok;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_tok.kind;
    assign o_out.field_number = r_tok.field_number;
    assign o_out.wire_type    = r_tok.wire_type;
    assign o_out.value        = r_tok.value;
    assign o_out.payload_byte = r_tok.payload_byte;
    assign o_out.payload_last = r_tok.payload_last;
    assign o_out.error_code   = r_tok.error_code;
    assign o_out.message_done = r_tok.message_done;

endmodule

// ===== hw/rtl/pwft_decode.sv =====
`include "assert_macros.svh"

module pwft_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  pwft_pkg::t_beat i_beat,
    output logic            o_emit,
    output pwft_pkg::t_token o_token
);
    import pwft_pkg::*;

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_idx, n_idx;
    logic [28:0] r_field, n_field;
    logic [2:0]  r_wt, n_wt;
    logic [63:0] r_remain, n_remain;

    logic [7:0]  b;
    logic        eom;
    logic [3:0]  idx_c;
    logic [5:0]  sh_v;
    logic [63:0] acc_v;
    logic        cont;
    logic        too_long;
    logic [63:0] acc_f;
    logic [3:0]  idx_f;
    logic        fixed_done;
    logic [63:0] rem_d;
    logic        last;
    logic [28:0] tag_field;
    logic [2:0]  tag_wt;
    logic        tag_wt_ok;

    logic        f_en;
    logic [28:0] f_fn;
    logic [2:0]  f_wt;
    logic [7:0]  f_pb;
    t_err        f_err;

    assign b     = i_beat.byte_value;
    assign eom   = i_beat.end_of_message;
    assign idx_c = (r_idx > VARINT_LAST_IDX) ? VARINT_LAST_IDX : r_idx;
    assign sh_v  = {2'b00, idx_c} * VARINT_DIGIT;
    assign acc_v = r_acc | ({57'd0, b[6:0]} << sh_v);
    assign cont  = b[7];
    assign too_long = cont && (idx_c >= VARINT_LAST_IDX);

    assign acc_f = r_acc | ({56'd0, b} << {r_idx[2:0], 3'b000});
    assign idx_f = r_idx + 4'd1;
    assign fixed_done = (r_wt == WT_FIXED64) ? (idx_f >= FIXED64_BYTES)
                                             : (idx_f >= FIXED32_BYTES);

    assign rem_d = (r_remain != 64'd0) ? (r_remain - 64'd1) : 64'd0;
    assign last  = (rem_d == 64'd0);

    assign tag_field = acc_v[31:3];
    assign tag_wt    = acc_v[2:0];
    assign tag_wt_ok = (tag_wt == WT_VARINT) || (tag_wt == WT_FIXED64) ||
                       (tag_wt == WT_LEN) || (tag_wt == WT_FIXED32);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_field  = r_field;
        n_wt     = r_wt;
        n_remain = r_remain;
        o_emit   = 1'b0;
        o_token  = '0;
        o_token.field_number = r_field;
        o_token.wire_type    = r_wt;
        f_en  = 1'b0;
        f_fn  = r_field;
        f_wt  = r_wt;
        f_pb  = 8'd0;
        f_err = ERR_NONE;

        case (r_phase)
            PH_VARINT, PH_LENGTH: begin
                if (too_long) begin
                    f_en  = 1'b1;
                    f_err = ERR_TOO_LONG;
                end else if (cont) begin
                    n_acc = acc_v;
                    n_idx = idx_c + 4'd1;
                    if (eom) begin
                        f_en  = 1'b1;
                        f_err = ERR_TRUNCATED;
                    end
                end else if (r_phase == PH_VARINT || acc_v == 64'd0) begin
                    o_emit = 1'b1;
                    o_token.kind  = (r_phase == PH_VARINT) ? KIND_SCALAR : KIND_LENGTH;
                    o_token.value = acc_v;
                    o_token.message_done = eom;
                    n_acc   = 64'd0;
                    n_idx   = 4'd0;
                    n_phase = PH_TAG;
                end else if (eom) begin
                    // A nonzero length on the final byte leaves its payload missing.
                    f_en  = 1'b1;
                    f_err = ERR_TRUNCATED;
                end else begin
                    o_emit = 1'b1;
                    o_token.kind  = KIND_LENGTH;
                    o_token.value = acc_v;
                    n_remain = acc_v;
                    n_acc    = 64'd0;
                    n_idx    = 4'd0;
                    n_phase  = PH_PAYLOAD;
                end
            end
            PH_FIXED: begin
                if (fixed_done) begin
                    o_emit = 1'b1;
                    o_token.kind  = KIND_SCALAR;
                    o_token.value = acc_f;
                    o_token.message_done = eom;
                    n_acc   = 64'd0;
                    n_idx   = 4'd0;
                    n_phase = PH_TAG;
                end else begin
                    n_acc = acc_f;
                    n_idx = idx_f;
                    if (eom) begin
                        f_en  = 1'b1;
                        f_err = ERR_TRUNCATED;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_remain = rem_d;
                if (!last && eom) begin
                    f_en  = 1'b1;
                    f_pb  = b;
                    f_err = ERR_TRUNCATED;
                end else begin
                    o_emit = 1'b1;
                    o_token.kind         = KIND_PAYLOAD;
                    o_token.payload_byte = b;
                    o_token.payload_last = last;
                    o_token.message_done = last && eom;
                    if (last) begin
                        n_acc   = 64'd0;
                        n_idx   = 4'd0;
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_SKIP: begin
                if (eom) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_TAG;
                if (too_long) begin
                    f_en  = 1'b1;
                    f_fn  = 29'd0;
                    f_wt  = 3'd0;
                    f_err = ERR_TOO_LONG;
                end else if (cont) begin
                    n_acc = acc_v;
                    n_idx = idx_c + 4'd1;
                    if (eom) begin
                        f_en  = 1'b1;
                        f_fn  = 29'd0;
                        f_wt  = 3'd0;
                        f_err = ERR_TRUNCATED;
                    end
                end else begin
                    n_field = tag_field;
                    n_wt    = tag_wt;
                    n_acc   = 64'd0;
                    n_idx   = 4'd0;
                    f_fn    = tag_field;
                    f_wt    = tag_wt;
                    if (!tag_wt_ok) begin
                        f_en  = 1'b1;
                        f_err = ERR_WIRE_TYPE;
                    end else if (eom) begin
                        f_en  = 1'b1;
                        f_err = ERR_TRUNCATED;
                    end else if (tag_wt == WT_VARINT) begin
                        n_phase = PH_VARINT;
                    end else if (tag_wt == WT_LEN) begin
                        n_phase = PH_LENGTH;
                    end else begin
                        n_phase = PH_FIXED;
                    end
                end
            end
        endcase

        // Any error drops the field; only a truncation or the final byte restarts at a tag.
        if (f_en) begin
            o_emit  = 1'b1;
            o_token = '0;
            o_token.kind         = KIND_ERROR;
            o_token.field_number = f_fn;
            o_token.wire_type    = f_wt;
            o_token.payload_byte = f_pb;
            o_token.error_code   = f_err;
            n_acc    = 64'd0;
            n_idx    = 4'd0;
            n_remain = 64'd0;
            n_phase  = (eom || f_err == ERR_TRUNCATED) ? PH_TAG : PH_SKIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_acc    <= 64'd0;
            r_idx    <= 4'd0;
            r_field  <= 29'd0;
            r_wt     <= 3'd0;
            r_remain <= 64'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_field  <= n_field;
            r_wt     <= n_wt;
            r_remain <= n_remain;
        end
    end

    `ASSERT_PROP(a_payload_has_bytes, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_remain != 64'd0))
    `ASSERT_PROP(a_skip_is_clear, i_clk, i_rst_n, (r_phase == PH_SKIP) |-> (r_acc == 64'd0 && r_idx == 4'd0))
    `ASSERT_NEVER(a_idx_in_range, i_clk, i_rst_n, r_idx > VARINT_LAST_IDX)
    `ASSERT_PROP(a_error_is_bare, i_clk, i_rst_n, (o_emit && o_token.kind == KIND_ERROR) |-> (!o_token.message_done && o_token.value == 64'd0))
    `ASSERT_PROP(a_hold_when_idle, i_clk, i_rst_n, (i_rst_n && !i_fire) |=> ($stable(r_phase) && $stable(r_acc) && $stable(r_remain)))

endmodule

// ===== dv/pwft_token_checker.sv =====
module pwft_token_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pwft_byte_if i_bytes,
    pwft_tok_if  i_tokens,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_beats_decoded,
    output int   o_tokens_checked,
    output int   o_error_tokens
);
    timeunit 1ns;
    timeprecision 1ps;

    import pwft_pkg::*;

    typedef enum logic [1:0] {
        VARINT_DONE,
        VARINT_MORE,
        VARINT_OVERLONG
    } t_varint_step;

    // Decoder state, kept in step with every accepted input beat.
    t_phase      phase_q;
    logic [63:0] acc_q;
    logic [3:0]  idx_q;
    logic [28:0] field_q;
    logic [2:0]  wtype_q;
    logic [63:0] remaining_q;

    t_token expected_tokens[$];
    t_token token_next;
    t_token token_want;
    int     mismatches     = 0;
    int     beats_decoded  = 0;
    int     tokens_checked = 0;
    int     error_tokens   = 0;

    function automatic void clear_field();
        acc_q = '0;
        idx_q = '0;
    endfunction

    function automatic t_varint_step take_varint_byte(input logic [7:0] b);
        logic [3:0] idx;
        idx = (idx_q > VARINT_LAST_IDX) ? VARINT_LAST_IDX : idx_q;
        // Bits that land above bit 63 on the tenth byte fall off the shift.
        acc_q |= {57'd0, b[6:0]} << (VARINT_DIGIT * idx);
        if (!b[7]) begin
            return VARINT_DONE;
        end
        if (idx >= VARINT_LAST_IDX) begin
            return VARINT_OVERLONG;
        end
        idx_q = idx + 4'd1;
        return VARINT_MORE;
    endfunction

    function automatic t_token make_token(input t_kind k, input logic [63:0] v,
                                          input logic [7:0] pb, input logic last,
                                          input logic done);
        t_token t;
        t.kind         = k;
        t.field_number = field_q;
        t.wire_type    = wtype_q;
        t.value        = v;
        t.payload_byte = pb;
        t.payload_last = last;
        t.error_code   = ERR_NONE;
        t.message_done = done;
        return t;
    endfunction

    function automatic bit raise_error(input logic [28:0] fn, input logic [2:0] wt,
                                       input logic [7:0] pb, input t_err err,
                                       input logic eom, output t_token tok);
        tok.kind         = KIND_ERROR;
        tok.field_number = fn;
        tok.wire_type    = wt;
        tok.value        = '0;
        tok.payload_byte = pb;
        tok.payload_last = 1'b0;
        tok.error_code   = err;
        tok.message_done = 1'b0;
        clear_field();
        remaining_q = '0;
        // A truncation always lands on the final byte, so decoding restarts at once.
        phase_q = (eom || err == ERR_TRUNCATED) ? PH_TAG : PH_SKIP;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic eom,
                                       output t_token tok);
        t_varint_step step;
        logic [3:0]   need;
        logic         last;
        t_kind        k;
        tok = '0;
        case (phase_q)
            PH_VARINT, PH_LENGTH: begin
                step = take_varint_byte(b);
                if (step == VARINT_OVERLONG) begin
                    return raise_error(field_q, wtype_q, 8'd0, ERR_TOO_LONG, eom, tok);
                end
                if (step == VARINT_MORE) begin
                    if (eom) begin
                        return raise_error(field_q, wtype_q, 8'd0, ERR_TRUNCATED, eom, tok);
                    end
                    return 1'b0;
                end
                // A zero length finishes the field with its header alone.
                if (phase_q == PH_VARINT || acc_q == 64'd0) begin
                    k = (phase_q == PH_VARINT) ? KIND_SCALAR : KIND_LENGTH;
                    tok = make_token(k, acc_q, 8'd0, 1'b0, eom);
                    clear_field();
                    phase_q = PH_TAG;
                    return 1'b1;
                end
                if (eom) begin
                    return raise_error(field_q, wtype_q, 8'd0, ERR_TRUNCATED, eom, tok);
                end
                tok = make_token(KIND_LENGTH, acc_q, 8'd0, 1'b0, 1'b0);
                remaining_q = acc_q;
                clear_field();
                phase_q = PH_PAYLOAD;
                return 1'b1;
            end
            PH_FIXED: begin
                need = (wtype_q == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                acc_q |= {56'd0, b} << (8 * idx_q[2:0]);
                idx_q = idx_q + 4'd1;
                if (idx_q >= need) begin
                    tok = make_token(KIND_SCALAR, acc_q, 8'd0, 1'b0, eom);
                    clear_field();
                    phase_q = PH_TAG;
                    return 1'b1;
                end
                if (eom) begin
                    return raise_error(field_q, wtype_q, 8'd0, ERR_TRUNCATED, eom, tok);
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                if (remaining_q != 64'd0) begin
                    remaining_q = remaining_q - 64'd1;
                end
                last = (remaining_q == 64'd0);
                // The lost byte travels with the truncation error.
                if (!last && eom) begin
                    return raise_error(field_q, wtype_q, b, ERR_TRUNCATED, eom, tok);
                end
                tok = make_token(KIND_PAYLOAD, 64'd0, b, last, last && eom);
                if (last) begin
                    clear_field();
                    phase_q = PH_TAG;
                end
                return 1'b1;
            end
            PH_SKIP: begin
                if (eom) begin
                    phase_q = PH_TAG;
                end
                return 1'b0;
            end
            default: begin
                phase_q = PH_TAG;
                step = take_varint_byte(b);
                // Errors inside the tag itself carry field zero and wire type zero.
                if (step == VARINT_OVERLONG) begin
                    return raise_error(29'd0, 3'd0, 8'd0, ERR_TOO_LONG, eom, tok);
                end
                if (step == VARINT_MORE) begin
                    if (eom) begin
                        return raise_error(29'd0, 3'd0, 8'd0, ERR_TRUNCATED, eom, tok);
                    end
                    return 1'b0;
                end
                field_q = acc_q[31:3];
                wtype_q = acc_q[2:0];
                clear_field();
                if (wtype_q != WT_VARINT && wtype_q != WT_FIXED64 &&
                    wtype_q != WT_LEN && wtype_q != WT_FIXED32) begin
                    return raise_error(field_q, wtype_q, 8'd0, ERR_WIRE_TYPE, eom, tok);
                end
                if (eom) begin
                    return raise_error(field_q, wtype_q, 8'd0, ERR_TRUNCATED, eom, tok);
                end
                if (wtype_q == WT_VARINT) begin
                    phase_q = PH_VARINT;
                end else if (wtype_q == WT_LEN) begin
                    phase_q = PH_LENGTH;
                end else begin
                    phase_q = PH_FIXED;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_q     = PH_TAG;
            acc_q       = '0;
            idx_q       = '0;
            field_q     = '0;
            wtype_q     = '0;
            remaining_q = '0;
            expected_tokens.delete();
        end else begin
            if (i_bytes.valid && i_bytes.ready) begin
                if (phase_q != PH_SKIP) begin
                    beats_decoded++;
                end
                if (decode_byte(i_bytes.byte_value, i_bytes.end_of_message, token_next)) begin
                    expected_tokens.push_back(token_next);
                end
            end
            if (i_tokens.valid && i_tokens.ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token beat with nothing expected: kind %0d, field %0d",
                           i_tokens.kind, i_tokens.field_number);
                    mismatches++;
                end else begin
                    token_want = expected_tokens.pop_front();
                    check_field("kind", token_want.kind, i_tokens.kind);
                    check_field("field_number", token_want.field_number,
                                i_tokens.field_number);
                    check_field("wire_type", token_want.wire_type, i_tokens.wire_type);
                    check_field("value", token_want.value, i_tokens.value);
                    check_field("payload_byte", token_want.payload_byte,
                                i_tokens.payload_byte);
                    check_field("payload_last", token_want.payload_last,
                                i_tokens.payload_last);
                    check_field("error_code", token_want.error_code, i_tokens.error_code);
                    check_field("message_done", token_want.message_done,
                                i_tokens.message_done);
                    tokens_checked++;
                    if (token_want.kind == KIND_ERROR) begin
                        error_tokens++;
                    end
                end
            end
        end
        o_mismatches     <= mismatches;
        o_pending        <= expected_tokens.size();
        o_beats_decoded  <= beats_decoded;
        o_tokens_checked <= tokens_checked;
        o_error_tokens   <= error_tokens;
    end

endmodule

// ===== dv/protobuf_wire_field_tokenizer_tb.sv =====
module protobuf_wire_field_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwft_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TARGET_BEATS = 1000;
    localparam int HOLD_CYCLES  = 400;

    // Wire types that the block must reject.
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_BAD6   = 3'd6;
    localparam logic [2:0] WT_BAD7   = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_off = 1'b0;

    int mismatches;
    int pending;
    int beats_decoded;
    int tokens_checked;
    int error_tokens;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count;
    int messages_sent = 0;

    logic [7:0] msg_bytes[$];

    pwft_byte_if byte_ch();
    pwft_tok_if  tok_ch();

    protobuf_wire_field_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (tok_ch)
    );

    pwft_token_checker token_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bytes          (byte_ch),
        .i_tokens         (tok_ch),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_beats_decoded  (beats_decoded),
        .o_tokens_checked (tokens_checked),
        .o_error_tokens   (error_tokens)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand_value();
        int          w;
        logic [63:0] v;
        w = $urandom_range(64, 0);
        v = {$urandom, $urandom};
        if (w < 64) begin
            v &= (64'd1 << w) - 64'd1;
        end
        return v;
    endfunction

    // Appends a varint, optionally padded out to a longer, non-minimal form.
    task automatic add_varint(input logic [63:0] v, input bit stretch);
        int          n;
        logic [63:0] sh;
        logic [7:0]  b;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0) begin
            n++;
        end
        if (stretch) begin
            n = $urandom_range(10, n);
        end
        for (int i = 0; i < n; i++) begin
            sh = v >> (7 * i);
            b  = {1'b0, sh[6:0]};
            // Only bit 0 of a tenth byte reaches the value; the rest must be dropped.
            if (i == 9) begin
                b[6:1] = 6'($urandom);
            end
            if (i < n - 1) begin
                b[7] = 1'b1;
            end
            msg_bytes.push_back(b);
        end
    endtask

    task automatic add_field();
        logic [28:0] fn;
        logic [2:0]  wt;
        logic [63:0] tag;
        int          len;
        case ($urandom_range(9, 0))
            0:       fn = '0;
            1:       fn = '1;
            2:       fn = 29'($urandom);
            default: fn = 29'($urandom_range(15, 1));
        endcase
        case ($urandom_range(3, 0))
            0:       wt = WT_VARINT;
            1:       wt = WT_FIXED64;
            2:       wt = WT_LEN;
            default: wt = WT_FIXED32;
        endcase
        tag = {32'd0, fn, wt};
        if ($urandom_range(15, 0) == 0) begin
            tag[63:32] = $urandom;
        end
        add_varint(tag, $urandom_range(9, 0) == 0);
        case (wt)
            WT_VARINT: begin
                if ($urandom_range(19, 0) == 0) begin
                    add_varint(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
                end else begin
                    add_varint(rand_value(), $urandom_range(9, 0) == 0);
                end
            end
            WT_LEN: begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 7)
                                                  : $urandom_range(6, 0);
                add_varint(64'(len), $urandom_range(9, 0) == 0);
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
            default: begin
                repeat ((wt == WT_FIXED64) ? 8 : 4) msg_bytes.push_back(8'($urandom));
            end
        endcase
    endtask

    task automatic send_beat(input logic [7:0] b, input logic eom);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid          <= 1'b1;
        byte_ch.byte_value     <= b;
        byte_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!byte_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++) begin
            send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
        end
        messages_sent++;
    endtask

    initial begin
        tok_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            tok_ch.ready <= i_rst_n && !hold_off &&
                            ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Long receiver stall while the sender keeps offering beats.
    initial begin
        wait (beats_decoded >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int          pick;
        int          cut;
        logic [28:0] fn_rand;
        logic [2:0]  bad_wt;
        logic [7:0]  rb;

        byte_ch.valid          = 1'b0;
        byte_ch.byte_value     = 8'd0;
        byte_ch.end_of_message = 1'b0;
        i_rst_n                = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 51;

        // Scalar zero on field 1, then the same on field zero.
        msg_bytes = {8'h08, 8'h00};
        send_message();
        msg_bytes = {8'h00, 8'h00};
        send_message();
        // Zero-length field, then a two-byte payload.
        msg_bytes = {8'h12, 8'h00};
        send_message();
        msg_bytes = {8'h1A, 8'h02, 8'hAB, 8'h54};
        send_message();
        msg_bytes = {8'h0D, 8'h00, 8'hFF, 8'h5A, 8'hA5};
        send_message();
        // Bad wire type on the last byte, then a complete tag whose value is cut off by the end of message.
        msg_bytes = {8'h0B};
        send_message();
        msg_bytes = {8'h08};
        send_message();
        // Truncated inside a payload, then right after a nonzero length.
        msg_bytes = {8'h1A, 8'h03, 8'h77};
        send_message();
        msg_bytes = {8'h12, 8'h05};
        send_message();
        // Overlong tag whose error byte is also the final byte.
        msg_bytes.delete();
        repeat (10) msg_bytes.push_back(8'h80);
        send_message();
        // Largest field number.
        msg_bytes = {8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h7F};
        send_message();

        while (beats_decoded < TARGET_BEATS) begin
            if (beats_decoded >= 700) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (beats_decoded >= 400) begin
                send_idle_pct = 51;
                recv_idle_pct = 12;
            end
            msg_bytes.delete();
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
                repeat ($urandom_range(8, 1)) msg_bytes.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(4, 1)) add_field();
                if (pick < 16) begin
                    if (msg_bytes.size() > 1) begin
                        cut = $urandom_range(msg_bytes.size() - 1, 1);
                        while (msg_bytes.size() > cut) begin
                            void'(msg_bytes.pop_back());
                        end
                    end
                end else if (pick < 23) begin
                    case ($urandom_range(3, 0))
                        0:       bad_wt = WT_SGROUP;
                        1:       bad_wt = WT_EGROUP;
                        2:       bad_wt = WT_BAD6;
                        default: bad_wt = WT_BAD7;
                    endcase
                    fn_rand = 29'($urandom);
                    add_varint({32'd0, fn_rand, bad_wt}, 1'b0);
                    repeat ($urandom_range(3, 0)) msg_bytes.push_back(8'($urandom));
                end else if (pick < 30) begin
                    // Overlong varint as a tag, a value or a length.
                    fn_rand = 29'($urandom_range(15, 1));
                    case ($urandom_range(2, 0))
                        1:       add_varint({32'd0, fn_rand, WT_VARINT}, 1'b0);
                        2:       add_varint({32'd0, fn_rand, WT_LEN}, 1'b0);
                        default: ;
                    endcase
                    repeat ($urandom_range(11, 10)) begin
                        rb    = 8'($urandom);
                        rb[7] = 1'b1;
                        msg_bytes.push_back(rb);
                    end
                    repeat ($urandom_range(3, 0)) msg_bytes.push_back(8'($urandom));
                end
            end
            send_message();
        end
        byte_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d messages with %0d decoded bytes under sender and receiver stalls.",
                 messages_sent, beats_decoded);
        $display("Checked %0d tokens, %0d of them error reports.", tokens_checked,
                 error_tokens);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
